@@ design/image_framer_with_crc16_macros.svh @@
// Assertion macros shared by the framer.
`ifndef IMAGE_FRAMER_WITH_CRC16_MACROS_SVH
`define IMAGE_FRAMER_WITH_CRC16_MACROS_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define IFR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every clock edge out of reset.
`define IFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ design/ifr_pkg.sv @@
package ifr_pkg;

    // Default depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;

    // CRC-16/X-25, reflected form.
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_XOROUT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h8408;

    // Framing bytes.
    localparam logic [7:0] HDR_MARK     = 8'h48;
    localparam logic [7:0] HDR_REVISION = 8'd10;
    localparam logic [7:0] END_MARK     = 8'h45;

    // One classified payload word as it travels through the queue.
    typedef struct packed {
        logic        first;
        logic        last;
        logic [7:0]  data;
        logic [31:0] length;
        logic [15:0] crc;
    } t_entry;

    // Front status seen by the top level.
    typedef struct packed {
        logic in_frame;
    } t_front_status;

endpackage

@@ design/ifr_front.sv @@
module ifr_front
    import ifr_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [7:0]    i_data_byte,
    input  logic          i_last_byte,
    input  logic [31:0]   i_payload_length,
    output t_entry        o_entry,
    output t_front_status o_status
);

    // Bitwise update of the reflected CRC by one byte.
    function automatic logic [15:0] f_crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    logic        r_inside;
    logic [15:0] r_crc;
    logic        n_inside;
    logic [15:0] n_crc;
    logic [15:0] crc_base;
    logic [15:0] crc_next;

    // A word that arrives outside a frame opens one with a fresh CRC.
    assign crc_base = r_inside ? r_crc : CRC_INIT;
    assign crc_next = f_crc_byte(crc_base, i_data_byte);

    always_comb begin
        n_inside = r_inside;
        n_crc    = r_crc;
        if (i_push) begin
            n_inside = !i_last_byte;
            n_crc    = i_last_byte ? CRC_INIT : crc_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_crc    <= CRC_INIT;
        end else begin
            r_inside <= n_inside;
            r_crc    <= n_crc;
        end
    end

    // The queue entry carries the finished CRC for the trailer.
    assign o_entry.first  = !r_inside;
    assign o_entry.last   = i_last_byte;
    assign o_entry.data   = i_data_byte;
    assign o_entry.length = i_payload_length;
    assign o_entry.crc    = crc_next ^ CRC_XOROUT;

    assign o_status.in_frame = r_inside;

endmodule

@@ design/ifr_queue.sv @@
module ifr_queue
    import ifr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  t_entry                     i_entry,
    input  logic                       i_pop,
    output t_entry                     o_entry,
    output logic                       o_full,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_entry          r_slot [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_entry = r_slot[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

@@ design/ifr_back.sv @@
module ifr_back
    import ifr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_entry     i_entry,
    input  logic       i_empty,
    output logic       o_pop,
    input  logic       i_stall,
    output logic       o_valid,
    output logic [7:0] o_out_byte,
    output logic       o_end_of_frame
);

    // Position of the next byte within one word's output.
    typedef enum logic [3:0] {
        ST_MARK, ST_REV, ST_ZERO0, ST_ZERO1, ST_ZERO2, ST_ZERO3,
        ST_LEN3, ST_LEN2, ST_LEN1, ST_LEN0,
        ST_DATA, ST_END, ST_CRC_HI, ST_CRC_LO
    } t_step;

    logic       r_busy;
    t_step      r_step;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_eof;
    t_step      cur_step;
    logic       load;
    logic       emit;
    logic [7:0] sel_byte;

    // A fresh word starts at the header if it opens a frame, else at its data.
    always_comb begin
        if (r_busy) begin
            cur_step = r_step;
        end else if (i_entry.first) begin
            cur_step = ST_MARK;
        end else begin
            cur_step = ST_DATA;
        end
    end

    assign load  = !r_valid || !i_stall;
    assign emit  = load && !i_empty;
    assign o_pop = emit && (((cur_step == ST_DATA) && !i_entry.last) || (cur_step == ST_CRC_LO));

    // Byte selection for the current position.
    always_comb begin
        case (cur_step)
            ST_MARK:   sel_byte = HDR_MARK;
            ST_REV:    sel_byte = HDR_REVISION;
            ST_LEN3:   sel_byte = i_entry.length[31:24];
            ST_LEN2:   sel_byte = i_entry.length[23:16];
            ST_LEN1:   sel_byte = i_entry.length[15:8];
            ST_LEN0:   sel_byte = i_entry.length[7:0];
            ST_DATA:   sel_byte = i_entry.data;
            ST_END:    sel_byte = END_MARK;
            ST_CRC_HI: sel_byte = i_entry.crc[15:8];
            ST_CRC_LO: sel_byte = i_entry.crc[7:0];
            default:   sel_byte = 8'h00;
        endcase
    end

    // Sequencer state and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_step  <= ST_MARK;
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= !i_empty;
            if (emit) begin
                r_byte <= sel_byte;
                r_eof  <= (cur_step == ST_CRC_LO);
                if (o_pop) begin
                    r_busy <= 1'b0;
                end else begin
                    r_busy <= 1'b1;
                    r_step <= t_step'(cur_step + 4'd1);
                end
            end
        end
    end

    assign o_valid        = r_valid;
    assign o_out_byte     = r_byte;
    assign o_end_of_frame = r_eof;

endmodule

@@ design/image_framer_with_crc16.sv @@
// Channel | Direction | Handshake         | Word
// input   | in        | i_valid / o_stall | i_data_byte, i_last_byte, i_payload_length
// output  | out       | o_valid / i_stall | o_out_byte, o_end_of_frame
//
// Each input word is queued with its CRC already updated.
// The output side sends one byte per cycle while i_stall is low and the queue holds a word;
// the back sequencer frames N payload bytes as N + 13 bytes with header and trailer.
// Input stalls only while the queue of DEPTH words (QUEUE_DEPTH by default) is full.
// Synchronous active-low reset empties the queue and closes any open frame; no clearing pass.
// The output register accepts a new byte in the same cycle it hands one over.
`include "image_framer_with_crc16_macros.svh"

module image_framer_with_crc16
    import ifr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic [31:0] i_payload_length,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_end_of_frame
);

    localparam int CW = $clog2(DEPTH + 1);

    t_entry          front_entry;
    t_entry          head_entry;
    t_front_status   front_status;
    logic            q_full;
    logic            q_empty;
    logic [CW-1:0]   q_count;
    logic            push;
    logic            pop;

    // A word is accepted whenever the queue has room.
    assign o_stall = q_full;
    assign push    = i_valid && !q_full;

    ifr_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .i_payload_length (i_payload_length),
        .o_entry          (front_entry),
        .o_status         (front_status)
    );

    ifr_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .i_pop   (pop),
        .o_entry (head_entry),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    ifr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_entry        (head_entry),
        .i_empty        (q_empty),
        .o_pop          (pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_out_byte     (o_out_byte),
        .o_end_of_frame (o_end_of_frame)
    );

    // Consistency checks across the front and the queue.
    `IFR_ASSERT_NOW(a_count_bound, 1'b1, q_count <= CW'(DEPTH), "queue count above depth")
    `IFR_ASSERT_NOW(a_no_idle_stall, q_count == '0, !o_stall, "stall with empty queue")
    `IFR_ASSERT_NEXT(a_last_closes, push && i_last_byte, !front_status.in_frame, "frame open")
    `IFR_ASSERT_NEXT(a_first_opens, push && !i_last_byte, front_status.in_frame, "frame shut")

endmodule
